>>> hdl/sts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Shared widths, operation codes and status codes of the sorted time ring
// schedule.
// ----------------------------------------------------------------------------
package sts_pkg;

	// Field widths of the command and result ports.
	localparam int TIME_W = 27;
	localparam int OP_W   = 3;
	localparam int ST_W   = 3;

	// Default number of schedule entries.
	localparam int DEPTH_DEFAULT = 16;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
	localparam logic [OP_W-1:0] OP_SEEK    = 3'd2;
	localparam logic [OP_W-1:0] OP_ADVANCE = 3'd3;
	localparam logic [OP_W-1:0] OP_READ    = 3'd4;

	// Status codes.
	localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
	localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd4;

endpackage

>>> hdl/sorted_time_ring_schedule.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_time_ring_schedule
// Sorted circular schedule of distinct times of day with a current-entry
// cursor, kept in a single-port-pair table memory.
// ----------------------------------------------------------------------------
// A command is transferred when start is high and busy is low; busy stays
// high until the result has been shown. Each command gives exactly one
// result, shown for a single cycle with done high; the receiver cannot stall
// it and must take it in that cycle. Advance, read and any command other
// than insert on an empty schedule go straight to the final read of the
// cursor entry. Insert, remove and seek first scan the N stored entries one
// memory read a cycle; an insert or remove that succeeds then shifts the
// entries above the slot through the same memory, one entry a cycle, before
// a final read of the cursor entry. The longest command is removing the
// first entry of a full table. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_time_ring_schedule #(
	parameter int DEPTH = sts_pkg::DEPTH_DEFAULT,
	parameter int IDX_W = $clog2(DEPTH),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [sts_pkg::OP_W-1:0]   op,
	input  logic [sts_pkg::TIME_W-1:0] time_value,
	output logic                       done,
	output logic [sts_pkg::TIME_W-1:0] current_time,
	output logic                       current_valid,
	output logic [CNT_W-1:0]           entry_count,
	output logic [sts_pkg::ST_W-1:0]   status
);

	logic                       mem_re;
	logic [IDX_W-1:0]           mem_raddr;
	logic [sts_pkg::TIME_W-1:0] mem_rdata;
	logic                       mem_we;
	logic [IDX_W-1:0]           mem_waddr;
	logic [sts_pkg::TIME_W-1:0] mem_wdata;

	// Command sequencer.
	sts_engine #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.time_value    (time_value),
		.done          (done),
		.current_time  (current_time),
		.current_valid (current_valid),
		.entry_count   (entry_count),
		.status        (status),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata)
	);

	// Time table.
	sts_table_ram #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_table (
		.clk   (clk),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata)
	);

endmodule

>>> hdl/sts_table_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_table_ram
// Time table storage: one write port and one read port, read data
// registered and valid in the cycle after the read is issued.
// ----------------------------------------------------------------------------
module sts_table_ram #(
	parameter int DEPTH = sts_pkg::DEPTH_DEFAULT,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      re,
	input  logic [IDX_W-1:0]          raddr,
	output logic [sts_pkg::TIME_W-1:0] rdata,
	input  logic                      we,
	input  logic [IDX_W-1:0]          waddr,
	input  logic [sts_pkg::TIME_W-1:0] wdata
);

	logic [sts_pkg::TIME_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/sts_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_engine
// Sequencer of the schedule: scans the table, shifts entries up or down
// through the memory, keeps the entry count and the cursor, and presents
// one result per command.
// ----------------------------------------------------------------------------
module sts_engine #(
	parameter int DEPTH = sts_pkg::DEPTH_DEFAULT,
	parameter int IDX_W = $clog2(DEPTH),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Command side.
	input  logic                       start,
	output logic                       busy,
	input  logic [sts_pkg::OP_W-1:0]   op,
	input  logic [sts_pkg::TIME_W-1:0] time_value,
	// Result side.
	output logic                       done,
	output logic [sts_pkg::TIME_W-1:0] current_time,
	output logic                       current_valid,
	output logic [CNT_W-1:0]           entry_count,
	output logic [sts_pkg::ST_W-1:0]   status,
	// Table memory.
	output logic                       mem_re,
	output logic [IDX_W-1:0]           mem_raddr,
	input  logic [sts_pkg::TIME_W-1:0] mem_rdata,
	output logic                       mem_we,
	output logic [IDX_W-1:0]           mem_waddr,
	output logic [sts_pkg::TIME_W-1:0] mem_wdata
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_SHUP  = 3'd2;
	localparam logic [2:0] S_SHDN  = 3'd3;
	localparam logic [2:0] S_FINAL = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [2:0]                 state_q;
	logic [sts_pkg::OP_W-1:0]   op_q;
	logic [sts_pkg::TIME_W-1:0] t_q;
	logic [sts_pkg::ST_W-1:0]   status_q;
	logic [CNT_W-1:0]           count_q;
	logic [IDX_W-1:0]           cursor_q;
	logic [CNT_W-1:0]           issue_q;
	logic                       vld_s1;
	logic [CNT_W-1:0]           idx_s1;
	logic                       found_q;
	logic [CNT_W-1:0]           found_pos_q;
	logic                       gt_seen_q;
	logic [CNT_W-1:0]           gt_pos_q;
	logic [CNT_W-1:0]           pos_q;

	logic [CNT_W-1:0] issue_m1;
	logic [CNT_W-1:0] count_m1;
	logic [CNT_W-1:0] cursor_ext;
	logic [CNT_W-1:0] ins_pos;
	logic [CNT_W-1:0] rm_cursor;
	logic             scan_end;
	logic             shup_end;
	logic             shdn_end;

	assign issue_m1   = issue_q - CNT_ONE;
	assign count_m1   = count_q - CNT_ONE;
	assign cursor_ext = CNT_W'(cursor_q);
	assign ins_pos    = gt_seen_q ? gt_pos_q : count_q;
	assign rm_cursor  = (pos_q < cursor_ext) ? (cursor_ext - CNT_ONE) : cursor_ext;
	assign scan_end   = (issue_q >= count_q) && !vld_s1;
	assign shup_end   = (issue_q == pos_q) && !vld_s1;
	assign shdn_end   = (issue_q >= count_q) && !vld_s1;

	// Memory port control for each phase of the command.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = t_q;
		case (state_q)
			S_SCAN: begin
				if (issue_q < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = issue_q[IDX_W-1:0];
				end
			end
			S_SHUP: begin
				if (issue_q > pos_q) begin
					mem_re    = 1'b1;
					mem_raddr = issue_m1[IDX_W-1:0];
				end
				if (vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s1[IDX_W-1:0];
					mem_wdata = mem_rdata;
				end else if (issue_q == pos_q) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q[IDX_W-1:0];
					mem_wdata = t_q;
				end
			end
			S_SHDN: begin
				if (issue_q < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = issue_q[IDX_W-1:0];
				end
				if (vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s1[IDX_W-1:0];
					mem_wdata = mem_rdata;
				end
			end
			S_FINAL: begin
				mem_re    = 1'b1;
				mem_raddr = cursor_q;
			end
			default: begin
			end
		endcase
	end

	// Command sequencer with count and cursor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			cursor_q  <= '0;
			vld_s1    <= 1'b0;
			found_q   <= 1'b0;
			gt_seen_q <= 1'b0;
			issue_q   <= '0;
			status_q  <= sts_pkg::ST_DONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q      <= op;
						t_q       <= time_value;
						found_q   <= 1'b0;
						gt_seen_q <= 1'b0;
						issue_q   <= '0;
						vld_s1    <= 1'b0;
						status_q  <= sts_pkg::ST_DONE;
						if (op == sts_pkg::OP_INSERT || (count_q != '0 &&
						    (op == sts_pkg::OP_REMOVE || op == sts_pkg::OP_SEEK))) begin
							state_q <= S_SCAN;
						end else begin
							if (count_q == '0) begin
								status_q <= sts_pkg::ST_EMPTY;
							end else if (op == sts_pkg::OP_ADVANCE) begin
								if (cursor_ext == count_m1) begin
									cursor_q <= '0;
								end else begin
									cursor_q <= cursor_q + IDX_W'(1);
								end
							end
							state_q <= S_FINAL;
						end
					end
				end
				S_SCAN: begin
					// Issue one read a cycle and compare the entry that returns.
					vld_s1 <= issue_q < count_q;
					idx_s1 <= issue_q;
					if (issue_q < count_q) begin
						issue_q <= issue_q + CNT_ONE;
					end
					if (vld_s1) begin
						if (mem_rdata == t_q && !found_q) begin
							found_q     <= 1'b1;
							found_pos_q <= idx_s1;
						end
						if (mem_rdata > t_q && !gt_seen_q) begin
							gt_seen_q <= 1'b1;
							gt_pos_q  <= idx_s1;
						end
					end
					if (scan_end) begin
						if (op_q == sts_pkg::OP_INSERT) begin
							if (found_q) begin
								status_q <= sts_pkg::ST_DUP;
								state_q  <= S_FINAL;
							end else if (count_q == CNT_FULL) begin
								status_q <= sts_pkg::ST_FULL;
								state_q  <= S_FINAL;
							end else begin
								pos_q   <= ins_pos;
								issue_q <= count_q;
								state_q <= S_SHUP;
							end
						end else if (op_q == sts_pkg::OP_REMOVE) begin
							if (!found_q) begin
								status_q <= sts_pkg::ST_NOTFOUND;
								state_q  <= S_FINAL;
							end else begin
								pos_q   <= found_pos_q;
								issue_q <= found_pos_q + CNT_ONE;
								state_q <= S_SHDN;
							end
						end else begin
							// Seek: unless the time is stored, first entry strictly after it, circularly.
							if (count_q >= CNT_TWO && !found_q) begin
								cursor_q <= gt_seen_q ? gt_pos_q[IDX_W-1:0] : '0;
							end
							state_q <= S_FINAL;
						end
					end
				end
				S_SHUP: begin
					// Move entries up by one from the top down to the insert slot.
					vld_s1 <= issue_q > pos_q;
					idx_s1 <= issue_q;
					if (issue_q > pos_q) begin
						issue_q <= issue_m1;
					end
					if (shup_end) begin
						count_q <= count_q + CNT_ONE;
						if (count_q != '0 && pos_q <= cursor_ext) begin
							cursor_q <= cursor_q + IDX_W'(1);
						end
						state_q <= S_FINAL;
					end
				end
				S_SHDN: begin
					// Move entries down by one over the removed slot.
					vld_s1 <= issue_q < count_q;
					idx_s1 <= issue_m1;
					if (issue_q < count_q) begin
						issue_q <= issue_q + CNT_ONE;
					end
					if (shdn_end) begin
						count_q <= count_m1;
						if (rm_cursor >= count_m1) begin
							cursor_q <= '0;
						end else begin
							cursor_q <= rm_cursor[IDX_W-1:0];
						end
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result presentation: the cursor entry arrives from the memory in S_OUT.
	assign busy          = state_q != S_IDLE;
	assign done          = state_q == S_OUT;
	assign current_valid = count_q != '0;
	assign current_time  = (count_q != '0) ? mem_rdata : '0;
	assign entry_count   = count_q;
	assign status        = status_q;

endmodule
